@@ rtl/assert_macros.svh @@
// Assertion helpers for the clustering block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/kmc_pkg.sv @@
package kmc_pkg;
  localparam int MaxPoints = 64;
  localparam int MaxClusters = 8;
  localparam int CoordBits = 16;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_SEED = 2'd1;
  localparam logic [1:0] OP_RUN = 2'd2;

  localparam logic CFG_NUM_CLUSTERS = 1'b0;
  localparam logic CFG_ITERATIONS = 1'b1;

  // Command that travels down the cell row.
  typedef struct packed {
    logic assign_go;
    logic seed_go;
  } kmc_ctl_t;
endpackage

@@ rtl/kmc_cell.sv @@
module kmc_cell import kmc_pkg::*; #(
  parameter int CB = CoordBits,
  parameter int CL = 3,
  parameter logic [CL-1:0] IDX = '0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  kmc_ctl_t             ctl,
  input  logic signed [CB-1:0] px,
  input  logic signed [CB-1:0] py,
  input  logic [CL-1:0]        seed_slot,
  input  logic signed [CB-1:0] new_x,
  input  logic signed [CB-1:0] new_y,
  input  logic                 upd,
  input  logic                 in_valid,
  input  logic [2*CB:0]        in_dist,
  input  logic [CL-1:0]        in_label,
  output logic                 out_valid,
  output logic [2*CB:0]        out_dist,
  output logic [CL-1:0]        out_label
);
  logic signed [CB-1:0] cx;
  logic signed [CB-1:0] cy;
  logic signed [CB:0] dx;
  logic signed [CB:0] dy;
  logic signed [2*CB+1:0] sqx;
  logic signed [2*CB+1:0] sqy;
  logic [2*CB:0] d;
  logic take;

  assign dx = {px[CB-1], px} - {cx[CB-1], cx};
  assign dy = {py[CB-1], py} - {cy[CB-1], cy};
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign d = (2*CB+1)'(sqx + sqy);
  assign take = en && (!in_valid || d <= in_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      cx <= '0;
      cy <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.seed_go && seed_slot == IDX) begin
        cx <= px;
        cy <= py;
      end else if (upd) begin
        cx <= new_x;
        cy <= new_y;
      end
      out_valid <= ctl.assign_go && (in_valid || en);
    end
  end

  always_ff @(posedge clk) begin
    out_dist <= take ? d : in_dist;
    out_label <= take ? IDX : in_label;
  end
endmodule

@@ rtl/kmc_divider.sv @@
module kmc_divider #(
  parameter int SW = 23,
  parameter int NW = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [SW-1:0] num,
  input  logic [NW-1:0]        den,
  output logic                 done,
  output logic signed [SW-1:0] quo
);
  localparam int CW = $clog2(SW + 1);
  logic [SW-1:0] mag;
  logic [SW-1:0] q;
  logic [NW:0] rem;
  logic [NW:0] trial;
  logic [NW-1:0] dv;
  logic neg;
  logic busy;
  logic [CW-1:0] cnt;

  assign trial = {rem[NW-1:0], mag[SW-1]} - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(SW);
        mag <= num[SW-1] ? SW'(-num) : SW'(num);
        neg <= num[SW-1];
        dv <= den;
        rem <= '0;
        q <= '0;
      end else if (busy) begin
        mag <= mag << 1;
        if (!trial[NW]) begin
          rem <= trial;
          q <= {q[SW-2:0], 1'b1};
        end else begin
          rem <= {rem[NW-1:0], mag[SW-1]};
          q <= {q[SW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? SW'(-q) : q;
endmodule

@@ rtl/k_means_2d_clustering.sv @@
// Append: input does not stall. Seed: input stalls while the word crosses the row.
// Run: per round, the points pass the cell row, then the divider forms each cluster's centroid;
// then one label word per cycle subject to stall, with the input stalled until the last label
// word is taken. Synchronous active-high reset clears state, point count, centroids and the
// label fill count (labels read as zero until first assigned) and sets the config registers to
// 2 clusters and 10 iterations; point stores stay undefined until written.
`include "assert_macros.svh"
module k_means_2d_clustering import kmc_pkg::*; #(
  parameter int MAX_POINTS = MaxPoints,
  parameter int MAX_CLUSTERS = MaxClusters,
  parameter int COORD_BITS = CoordBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic [5:0]  point_slot,
  input  logic [2:0]  cluster_slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  point_number,
  output logic [2:0]  cluster_label,
  output logic        is_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  localparam int PB = $clog2(MAX_POINTS);
  localparam int PCB = $clog2(MAX_POINTS + 1);
  localparam int CL = $clog2(MAX_CLUSTERS);
  localparam int CB = COORD_BITS;
  localparam int SW = COORD_BITS + 7;
  localparam int NW = PCB;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FEED = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_DIVW = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_SEED = 3'd6;

  logic [2:0] state;
  logic [3:0] num_clusters;
  logic [7:0] iteration_count;
  logic [7:0] iter_left;
  logic [PCB-1:0] point_count;
  logic [PCB-1:0] lab_count;
  logic [CL:0] k_use;

  logic signed [CB-1:0] pxs [MAX_POINTS];
  logic signed [CB-1:0] pys [MAX_POINTS];
  logic [CL-1:0] labels [MAX_POINTS];
  logic signed [CB-1:0] rd_x;
  logic signed [CB-1:0] rd_y;
  logic [PB-1:0] rd_addr;
  logic [PB-1:0] rd_addr_q;
  logic rd_go;
  logic [CL-1:0] seed_slot;

  logic [PCB-1:0] feed_idx;
  logic [PCB-1:0] emit_idx;

  logic signed [SW-1:0] sum_x [MAX_CLUSTERS];
  logic signed [SW-1:0] sum_y [MAX_CLUSTERS];
  logic [NW-1:0] mcount [MAX_CLUSTERS];

  logic [CL-1:0] div_c;
  logic div_y;
  logic div_start;
  logic div_done;
  logic signed [SW-1:0] quo;
  logic signed [CB-1:0] qx;
  logic signed [CB-1:0] hold_x;

  kmc_ctl_t ctl [MAX_CLUSTERS+1];
  logic cv [MAX_CLUSTERS+1];
  logic [2*CB:0] cd [MAX_CLUSTERS+1];
  logic [CL-1:0] cl_l [MAX_CLUSTERS+1];
  logic signed [CB-1:0] cpx [MAX_CLUSTERS+1];
  logic signed [CB-1:0] cpy [MAX_CLUSTERS+1];
  logic [PB-1:0] cidx [MAX_CLUSTERS+1];

  logic in_take;
  logic feeding;

  assign in_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign in_take = in_valid && !in_stall;
  assign k_use = (num_clusters == 4'd0) ? (CL+1)'(1) :
                 (32'(num_clusters) > MAX_CLUSTERS) ? (CL+1)'(MAX_CLUSTERS) :
                 (CL+1)'(num_clusters);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters <= 4'd2;
      iteration_count <= 8'd10;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_CLUSTERS: num_clusters <= cfg_data[3:0];
        CFG_ITERATIONS: iteration_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // point store
  always_ff @(posedge clk) begin
    if (in_take && op == OP_APPEND && 32'(point_count) < MAX_POINTS) begin
      pxs[point_count[PB-1:0]] <= CB'(coord_x);
      pys[point_count[PB-1:0]] <= CB'(coord_y);
    end
    rd_x <= pxs[rd_addr];
    rd_y <= pys[rd_addr];
    rd_addr_q <= rd_addr;
  end

  assign feeding = (state == S_FEED) && (iter_left != 8'd0);
  assign rd_addr = (state == S_IDLE) ? PB'(point_slot) : feed_idx[PB-1:0];

  // cell row
  always_comb begin
    ctl[0].assign_go = rd_go && (state == S_FEED || state == S_DRAIN);
    ctl[0].seed_go = rd_go && (state == S_SEED);
  end
  assign cv[0] = 1'b0;
  assign cd[0] = '1;
  assign cl_l[0] = '0;
  assign cpx[0] = rd_x;
  assign cpy[0] = rd_y;
  assign cidx[0] = rd_addr_q;

  for (genvar c = 0; c < MAX_CLUSTERS; c++) begin : g_cell
    logic en;
    kmc_ctl_t cc;
    assign en = (32'(c) < 32'(k_use)) && ctl[c].assign_go;
    assign cc.assign_go = ctl[c].assign_go;
    assign cc.seed_go = ctl[c].seed_go;
    kmc_cell #(.CB(CB), .CL(CL), .IDX(CL'(c))) u_cell (
      .clk(clk), .rst(rst), .en(en), .ctl(cc),
      .px(cpx[c]), .py(cpy[c]), .seed_slot(seed_slot),
      .new_x(hold_x), .new_y(qx),
      .upd(div_y && div_done && div_c == CL'(c) && (32'(c) < 32'(k_use))
           && mcount[c] != '0),
      .in_valid(cv[c]), .in_dist(cd[c]), .in_label(cl_l[c]),
      .out_valid(cv[c+1]), .out_dist(cd[c+1]), .out_label(cl_l[c+1])
    );
    always_ff @(posedge clk) begin
      if (rst) ctl[c+1] <= '0;
      else ctl[c+1] <= cc;
      cpx[c+1] <= cpx[c];
      cpy[c+1] <= cpy[c];
      cidx[c+1] <= cidx[c];
    end
  end

  assign qx = CB'(quo);

  kmc_divider #(.SW(SW), .NW(NW)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(div_y ? sum_y[div_c] : sum_x[div_c]),
    .den(mcount[div_c]), .done(div_done), .quo(quo)
  );

  // label store
  always_ff @(posedge clk) begin
    if (ctl[MAX_CLUSTERS].assign_go) labels[cidx[MAX_CLUSTERS]] <= cl_l[MAX_CLUSTERS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      point_count <= '0;
      lab_count <= '0;
      rd_go <= 1'b0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      rd_go <= 1'b0;
      div_start <= 1'b0;
      if (ctl[MAX_CLUSTERS].assign_go) begin
        sum_x[cl_l[MAX_CLUSTERS]] <= sum_x[cl_l[MAX_CLUSTERS]]
                                     + SW'(cpx[MAX_CLUSTERS]);
        sum_y[cl_l[MAX_CLUSTERS]] <= sum_y[cl_l[MAX_CLUSTERS]]
                                     + SW'(cpy[MAX_CLUSTERS]);
        mcount[cl_l[MAX_CLUSTERS]] <= mcount[cl_l[MAX_CLUSTERS]] + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            case (op)
              OP_APPEND: if (32'(point_count) < MAX_POINTS)
                point_count <= point_count + 1'b1;
              OP_SEED: if (PCB'(point_slot) < point_count
                           && 32'(cluster_slot) < MAX_CLUSTERS) begin
                seed_slot <= CL'(cluster_slot);
                rd_go <= 1'b1;
                state <= S_SEED;
              end
              OP_RUN: begin
                iter_left <= iteration_count;
                if (iteration_count != 8'd0) lab_count <= point_count;
                feed_idx <= '0;
                emit_idx <= '0;
                for (int c = 0; c < MAX_CLUSTERS; c++) begin
                  sum_x[c] <= '0;
                  sum_y[c] <= '0;
                  mcount[c] <= '0;
                end
                state <= (point_count == '0) ? S_IDLE : S_FEED;
              end
              default: ;
            endcase
          end
        end
        S_SEED: begin
          if (ctl[MAX_CLUSTERS].seed_go) state <= S_IDLE;
        end
        S_FEED: begin
          if (!feeding) begin
            state <= S_EMIT;
          end else begin
            rd_go <= 1'b1;
            feed_idx <= feed_idx + 1'b1;
            if (feed_idx + 1'b1 == point_count) begin
              state <= S_DRAIN;
              emit_idx <= '0;
            end
          end
        end
        S_DRAIN: begin
          emit_idx <= emit_idx + 1'b1;
          if (32'(emit_idx) == MAX_CLUSTERS + 3) begin
            div_c <= '0;
            div_y <= 1'b0;
            div_start <= 1'b1;
            state <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            if (!div_y) begin
              hold_x <= qx;
              div_y <= 1'b1;
              div_start <= 1'b1;
            end else begin
              div_y <= 1'b0;
              if (32'(div_c) + 1 >= 32'(k_use)) state <= S_DIV;
              else begin
                div_c <= div_c + 1'b1;
                div_start <= 1'b1;
              end
            end
          end
        end
        S_DIV: begin
          for (int c = 0; c < MAX_CLUSTERS; c++) begin
            sum_x[c] <= '0;
            sum_y[c] <= '0;
            mcount[c] <= '0;
          end
          iter_left <= iter_left - 1'b1;
          feed_idx <= '0;
          emit_idx <= '0;
          state <= S_FEED;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            if (emit_idx == point_count) begin
              out_valid <= 1'b0;
              state <= S_IDLE;
            end else begin
              out_valid <= 1'b1;
              point_number <= 6'(emit_idx);
              cluster_label <= (emit_idx < lab_count) ?
                               3'(labels[emit_idx[PB-1:0]]) : 3'd0;
              is_last <= (emit_idx + 1'b1 == point_count);
              emit_idx <= emit_idx + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLY(a_stall_busy, clk, rst, state != S_IDLE, in_stall,
    "input taken while busy")
  `ASSERT_IMPLY(a_cfg_idle, clk, rst, cfg_ready, state == S_IDLE,
    "config while busy")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(point_number), "output word dropped")
  `ASSERT_IMPLY(a_row_valid, clk, rst, ctl[MAX_CLUSTERS].assign_go,
    cv[MAX_CLUSTERS] && !(&cd[MAX_CLUSTERS]), "point left the row unassigned")
endmodule

@@ tb/testbench.sv @@
module testbench;
  import kmc_pkg::*;

  localparam logic [1:0] OpSpare = 2'd3;
  localparam int IdleLimit = 600000;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [5:0]         pslot;
    logic [2:0]         cslot;
  } cmd_t;

  typedef struct packed {
    logic [5:0] pnum;
    logic [2:0] label;
    logic       last;
  } label_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = '0;
  logic signed [15:0] coord_x = '0;
  logic signed [15:0] coord_y = '0;
  logic [5:0] point_slot = '0;
  logic [2:0] cluster_slot = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] point_number;
  logic [2:0] cluster_label;
  logic is_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_data = '0;

  k_means_2d_clustering u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .coord_x(coord_x), .coord_y(coord_y),
    .point_slot(point_slot), .cluster_slot(cluster_slot),
    .out_valid(out_valid), .out_stall(out_stall),
    .point_number(point_number), .cluster_label(cluster_label), .is_last(is_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // cluster model state
  logic signed [15:0] pt_x [MaxPoints];
  logic signed [15:0] pt_y [MaxPoints];
  logic signed [15:0] cen_x [MaxClusters] = '{default: '0};
  logic signed [15:0] cen_y [MaxClusters] = '{default: '0};
  logic [2:0] labels [MaxPoints] = '{default: '0};
  int n_points = 0;
  logic [3:0] k_reg = 4'd2;
  logic [7:0] rounds_reg = 8'd10;
  bit empty_run = 0;

  cmd_t pending [$];
  label_t label_q [$];
  int errs = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit burst = 0;
  bit press_go = 0;
  bit press_done = 0;
  int idle_cnt = 0;
  int plan_pts = 0;
  int centre_x [4];
  int centre_y [4];

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int k_used();
    int k;
    k = k_reg;
    if (k == 0) k = 1;
    if (k > MaxClusters) k = MaxClusters;
    return k;
  endfunction

  function automatic void lloyd_round(int k);
    longint sx [MaxClusters];
    longint sy [MaxClusters];
    longint cnt [MaxClusters];
    longint dx, dy;
    longint unsigned d, best;
    for (int p = 0; p < n_points; p++) begin
      best = '1;
      for (int c = 0; c < k; c++) begin
        dx = longint'(pt_x[p]) - longint'(cen_x[c]);
        dy = longint'(pt_y[p]) - longint'(cen_y[c]);
        d = longint'(dx * dx) + longint'(dy * dy);
        if (d <= best) begin
          best = d;
          labels[p] = c[2:0];
        end
      end
    end
    for (int c = 0; c < MaxClusters; c++) begin
      sx[c] = 0; sy[c] = 0; cnt[c] = 0;
    end
    for (int p = 0; p < n_points; p++) begin
      sx[labels[p]] += pt_x[p];
      sy[labels[p]] += pt_y[p];
      cnt[labels[p]]++;
    end
    for (int c = 0; c < k; c++) begin
      if (cnt[c] != 0) begin
        cen_x[c] = 16'(sx[c] / cnt[c]);
        cen_y[c] = 16'(sy[c] / cnt[c]);
      end
    end
  endfunction

  function automatic void predict_labels(cmd_t c);
    label_t e;
    empty_run = 0;
    case (c.op)
      OP_APPEND: begin
        if (n_points < MaxPoints) begin
          pt_x[n_points] = c.x;
          pt_y[n_points] = c.y;
          n_points++;
        end
      end
      OP_SEED: begin
        if (c.pslot < n_points) begin
          cen_x[c.cslot] = pt_x[c.pslot];
          cen_y[c.cslot] = pt_y[c.pslot];
        end
      end
      OP_RUN: begin
        for (int i = 0; i < rounds_reg; i++) lloyd_round(k_used());
        for (int p = 0; p < n_points; p++) begin
          e.pnum = p[5:0];
          e.label = labels[p];
          e.last = (p + 1 == n_points);
          label_q = {label_q, e};
        end
        empty_run = (n_points == 0);
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        c = '{op, coord_x, coord_y, point_slot, cluster_slot};
        predict_labels(c);
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending.size() > 0) begin
          c = pending.pop_front();
          op <= c.op;
          coord_x <= c.x;
          coord_y <= c.y;
          point_slot <= c.pslot;
          cluster_slot <= c.cslot;
          in_valid <= 1'b1;
          gap_left = burst ? 0 : $urandom_range(0, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    label_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (label_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected label word: point %0d label %0d last %0d",
                     point_number, cluster_label, is_last);
        end else begin
          e = label_q.pop_front();
          if (e.pnum !== point_number || e.label !== cluster_label || e.last !== is_last) begin
            errs++;
            if (errs <= 10)
              $display("label mismatch: exp point %0d label %0d last %0d, got %0d %0d %0d",
                       e.pnum, e.label, e.last, point_number, cluster_label, is_last);
          end
        end
        stall_left = burst ? 0 : $urandom_range(0, 17);
      end
      if (press_go && !press_done && label_q.size() > 0) begin
        hold_left = 600;
        press_done = 1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cnt = 0;
    else
      idle_cnt++;
    if (idle_cnt >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_cmd(logic [1:0] o, int x, int y, int ps, int cs);
    cmd_t c;
    c.op = o;
    c.x = x[15:0];
    c.y = y[15:0];
    c.pslot = ps[5:0];
    c.cslot = cs[2:0];
    pending = {pending, c};
    if (o == OP_APPEND && plan_pts < MaxPoints) plan_pts++;
  endtask

  task automatic drain();
    int wait_cycles;
    @(posedge clk);
    while (pending.size() > 0 || in_valid || label_q.size() > 0) @(posedge clk);
    wait_cycles = 16;
    if (empty_run)
      wait_cycles += rounds_reg * (n_points + k_used() + 2 + k_used() * 50);
    repeat (wait_cycles) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_NUM_CLUSTERS) k_reg = val[3:0];
    else rounds_reg = val;
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int r, cx, cy, w, sel;
    for (int c = 0; c < 4; c++) begin
      centre_x[c] = $urandom_range(0, 60000) - 30000;
      centre_y[c] = $urandom_range(0, 60000) - 30000;
    end
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if ($urandom_range(0, 4) != 0) begin
          sel = $urandom_range(0, 3);
          w = $urandom_range(0, 2000);
          cx = centre_x[sel] + $urandom_range(0, 2 * w) - w;
          cy = centre_y[sel] + $urandom_range(0, 2 * w) - w;
        end else begin
          cx = $urandom;
          cy = $urandom;
        end
        push_cmd(OP_APPEND, cx, cy, $urandom, $urandom);
      end else if (r < 80) begin
        if ($urandom_range(0, 9) < 7 && plan_pts > 0)
          push_cmd(OP_SEED, $urandom, $urandom, $urandom_range(0, plan_pts - 1), $urandom);
        else
          push_cmd(OP_SEED, $urandom, $urandom, $urandom_range(0, 63), $urandom);
      end else if (r < 92) begin
        push_cmd(OP_RUN, $urandom, $urandom, $urandom, $urandom);
      end else begin
        push_cmd(OpSpare, $urandom, $urandom, $urandom, $urandom);
      end
    end
    push_cmd(OP_RUN, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_cmd(OP_RUN, 0, 0, 0, 0);
    push_cmd(OpSpare, -1, -1, 63, 7);
    push_cmd(OP_SEED, 0, 0, 5, 0);
    push_cmd(OP_APPEND, -32768, -32768, 0, 0);
    push_cmd(OP_APPEND, 32767, 32767, 63, 7);
    push_cmd(OP_APPEND, -32768, 32767, 0, 0);
    push_cmd(OP_APPEND, 32767, -32768, 0, 0);
    push_cmd(OP_APPEND, 0, 0, 0, 0);
    push_cmd(OP_APPEND, -1, -1, 0, 0);
    push_cmd(OP_APPEND, 0, 0, 0, 0);
    push_cmd(OP_APPEND, 100, -100, 0, 0);
    push_cmd(OP_SEED, -1, -1, 0, 0);
    push_cmd(OP_SEED, 0, 0, 1, 1);
    push_cmd(OP_SEED, 0, 0, 63, 7);
    push_cmd(OP_RUN, 0, 0, 0, 0);
    drain();

    write_reg(CFG_NUM_CLUSTERS, 8'd8);
    write_reg(CFG_ITERATIONS, 8'd1);
    push_cmd(OP_SEED, 0, 0, 2, 7);
    push_cmd(OP_SEED, 0, 0, 3, 4);
    for (int i = 0; i < 12; i++) push_cmd(OP_APPEND, $urandom, $urandom, 0, 0);
    push_cmd(OP_RUN, 0, 0, 0, 0);
    for (int i = 0; i < 10; i++) push_cmd(OP_APPEND, $urandom, $urandom, 0, 0);
    push_cmd(OP_RUN, 0, 0, 0, 0);
    press_go = 1;
    drain();

    write_reg(CFG_NUM_CLUSTERS, 8'd0);
    write_reg(CFG_ITERATIONS, 8'd0);
    push_cmd(OP_RUN, 0, 0, 0, 0);
    drain();

    write_reg(CFG_NUM_CLUSTERS, 8'hFF);
    write_reg(CFG_ITERATIONS, 8'd255);
    push_cmd(OP_RUN, 0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      burst = (ph % 3 == 1);
      write_reg(CFG_NUM_CLUSTERS, 8'($urandom_range(1, 8)));
      write_reg(CFG_ITERATIONS, 8'($urandom_range(1, 4)));
      random_phase(30);
      drain();
    end

    repeat (50) @(posedge clk);
    if (errs == 0 && label_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/kmc_pkg.sv
rtl/kmc_cell.sv
rtl/kmc_divider.sv
rtl/k_means_2d_clustering.sv
tb/testbench.sv
